@@ rtl/lkvc_pkg.sv @@
// Package for the LFU key-value cache: sizes, item structs, stored entry and controller states.
// It depends on nothing else in the project.
package lkvc_pkg;

  localparam int Entries    = 16;
  localparam int CountWidth = 16;
  localparam int CapWidth   = 5;
  localparam int IdxWidth   = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int RankWidth  = IdxWidth;
  localparam int OccWidth   = $clog2(Entries + 1);

  localparam logic [CapWidth-1:0] CapReset = CapWidth'(16);

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } action_e;

  typedef struct packed {
    logic               action;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
  } res_t;

  typedef struct packed {
    logic                  valid;
    logic [31:0]           key;
    logic [31:0]           value;
    logic [CountWidth-1:0] count;
    logic [RankWidth-1:0]  rank;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } state_e;

endpackage

@@ rtl/lfu_key_value_cache_unit.sv @@
// Top level of the LFU key-value cache: a ring of entry cells and the controller that scans it.
// Depends on lkvc_pkg and lkvc_cell.
//
//   channel   direction  handshake                 payload
//   request   in         start, busy               req_i (action, key, value)
//   result    out        done_o strobe, one cycle  res_o (hit, read_value)
//   config    in         cfg_valid_i, cfg_ready_o  cfg_data_i (capacity_in_use)
//
// An item takes one full turn of the ring to find the key, the victim and a free slot, one
// more turn to apply the update, then the result cycle.
// With a capacity of zero an item skips both ring turns and goes straight to the result.
// Reset empties the cache and sets the capacity to 16. Results cannot be stalled.
module lfu_key_value_cache_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  lkvc_pkg::req_t                   req_i,
  output logic                             done_o,
  output lkvc_pkg::res_t                   res_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lkvc_pkg::CapWidth-1:0]    cfg_data_i
);
  import lkvc_pkg::*;

  state_e state_q, state_d;
  logic [CapWidth-1:0]   cap_q;
  logic [OccWidth-1:0]   occ_q, occ_d;
  logic [IdxWidth-1:0]   pos_q, pos_d;
  req_t                  req_q;

  logic                  found_q, found_d;
  logic [IdxWidth-1:0]   hit_idx_q, hit_idx_d;
  logic [RankWidth-1:0]  hit_rank_q, hit_rank_d;
  logic [31:0]           hit_val_q, hit_val_d;
  logic                  vic_have_q, vic_have_d;
  logic [IdxWidth-1:0]   vic_idx_q, vic_idx_d;
  logic [CountWidth-1:0] vic_cnt_q, vic_cnt_d;
  logic [RankWidth-1:0]  vic_rank_q, vic_rank_d;
  logic [IdxWidth-1:0]   free_idx_q, free_idx_d;

  entry_t chain [Entries];
  entry_t head, tail_in;
  logic   shift;
  logic   last, full, is_put, do_write, all_age;
  logic [IdxWidth-1:0]  tgt_idx;
  logic [RankWidth-1:0] thr;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != ST_IDLE);
  assign head        = chain[0];
  assign last        = (pos_q == IdxWidth'(Entries - 1));
  assign is_put      = (req_q.action == ACT_PUT);
  assign full        = (32'(occ_q) >= 32'(cap_q)) || (32'(occ_q) == 32'(Entries));
  assign do_write    = found_q || is_put;
  assign all_age     = is_put && !found_q && !full;
  assign tgt_idx     = found_q ? hit_idx_q : (full ? vic_idx_q : free_idx_q);
  assign thr         = found_q ? hit_rank_q : vic_rank_q;

  for (genvar i = 0; i < Entries; i++) begin : g_ring
    entry_t cell_in;
    if (i == Entries - 1) begin : g_tail
      assign cell_in = tail_in;
    end else begin : g_mid
      assign cell_in = chain[i+1];
    end
    lkvc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i (cell_in),
      .entry_o (chain[i])
    );
  end

  always_comb begin
    tail_in = head;
    if (state_q == ST_UPDATE && do_write) begin
      if (pos_q == tgt_idx) begin
        if (found_q) begin
          if (head.count != {CountWidth{1'b1}}) begin
            tail_in.count = head.count + CountWidth'(1);
          end
          tail_in.rank = '0;
          if (is_put) begin
            tail_in.value = req_q.value;
          end
        end else begin
          tail_in.valid = 1'b1;
          tail_in.key   = req_q.key;
          tail_in.value = req_q.value;
          tail_in.count = CountWidth'(1);
          tail_in.rank  = '0;
        end
      end else if (head.valid && (all_age || head.rank < thr)) begin
        tail_in.rank = head.rank + RankWidth'(1);
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    occ_d      = occ_q;
    shift      = 1'b0;
    done_o     = 1'b0;
    found_d    = found_q;
    hit_idx_d  = hit_idx_q;
    hit_rank_d = hit_rank_q;
    hit_val_d  = hit_val_q;
    vic_have_d = vic_have_q;
    vic_idx_d  = vic_idx_q;
    vic_cnt_d  = vic_cnt_q;
    vic_rank_d = vic_rank_q;
    free_idx_d = free_idx_q;
    case (state_q)
      ST_IDLE: begin
        pos_d      = '0;
        found_d    = 1'b0;
        vic_have_d = 1'b0;
        if (start) begin
          state_d = (cap_q == '0) ? ST_RESP : ST_SCAN;
        end
      end
      ST_SCAN: begin
        shift = 1'b1;
        pos_d = pos_q + IdxWidth'(1);
        if (head.valid && head.key == req_q.key) begin
          found_d    = 1'b1;
          hit_idx_d  = pos_q;
          hit_rank_d = head.rank;
          hit_val_d  = head.value;
        end
        if (!head.valid) begin
          free_idx_d = pos_q;
        end
        if (head.valid && (!vic_have_q || head.count < vic_cnt_q ||
            (head.count == vic_cnt_q && head.rank > vic_rank_q))) begin
          vic_have_d = 1'b1;
          vic_idx_d  = pos_q;
          vic_cnt_d  = head.count;
          vic_rank_d = head.rank;
        end
        if (last) begin
          pos_d   = '0;
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        shift = 1'b1;
        pos_d = pos_q + IdxWidth'(1);
        if (last) begin
          pos_d   = '0;
          state_d = ST_RESP;
          if (all_age) begin
            occ_d = occ_q + OccWidth'(1);
          end
        end
      end
      ST_RESP: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_o.hit        = found_q;
    res_o.read_value = (found_q && !is_put) ? hit_val_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cap_q      <= CapReset;
      occ_q      <= '0;
      pos_q      <= '0;
      found_q    <= 1'b0;
      vic_have_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      occ_q      <= occ_d;
      pos_q      <= pos_d;
      found_q    <= found_d;
      vic_have_q <= vic_have_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
    hit_idx_q  <= hit_idx_d;
    hit_rank_q <= hit_rank_d;
    hit_val_q  <= hit_val_d;
    vic_idx_q  <= vic_idx_d;
    vic_cnt_q  <= vic_cnt_d;
    vic_rank_q <= vic_rank_d;
    free_idx_q <= free_idx_d;
  end

  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy)
    else $error("busy held after result");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.hit) |-> (res_o.read_value == '0))
    else $error("miss returned a nonzero value");
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(occ_q) <= 32'(Entries))
    else $error("occupancy beyond entry count");

endmodule

@@ rtl/lkvc_cell.sv @@
// One storage cell of the rotating entry ring: holds one cache entry and passes it on when shifted.
// Depends on lkvc_pkg.
module lkvc_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  lkvc_pkg::entry_t entry_i,
  output lkvc_pkg::entry_t entry_o
);
  import lkvc_pkg::*;

  logic   valid_q;
  entry_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= entry_i;
    end
  end

  always_comb begin
    entry_o       = data_q;
    entry_o.valid = valid_q;
  end

endmodule
